// File: rtl/lkvc_pkg.sv
// shared types and constants of the lru key-value cache
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W              = 32;
    localparam int FUNC_W             = 2;
    localparam int CFG_W              = 6;
    localparam int FLAG_W             = 2;
    localparam int DEFAULT_ENTRIES    = 32;
    localparam int DEFAULT_VALUE_BITS = 64;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 6'd20;

    // operation codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET    = 2'd0,
        FUNC_PUT    = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    // how the row of cells moves its entries in an update cycle
    typedef enum logic [1:0] {
        SHIFT_HOLD   = 2'd0,
        SHIFT_FRONT  = 2'd1,
        SHIFT_REMOVE = 2'd2
    } shift_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_UPDATE = 2'd2
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic active;
        logic found;
    } tok_t;

endpackage

`default_nettype wire

// File: rtl/lkvc_cell.sv
// one cell of the recency-ordered entry chain
`default_nettype none

module lkvc_cell #(
    parameter int ENTRIES    = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int VALUE_BITS = lkvc_pkg::DEFAULT_VALUE_BITS,
    parameter int INDEX      = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lkvc_pkg::shift_t              shift_mode,
    input  wire logic [$clog2(ENTRIES)-1:0]    shift_pos,
    input  wire logic [lkvc_pkg::KEY_W-1:0]    lookup_key,
    input  wire logic                          prev_valid,
    input  wire logic [lkvc_pkg::KEY_W-1:0]    prev_key,
    input  wire logic [VALUE_BITS-1:0]         prev_value,
    input  wire logic                          next_valid,
    input  wire logic [lkvc_pkg::KEY_W-1:0]    next_key,
    input  wire logic [VALUE_BITS-1:0]         next_value,
    output logic                               ent_valid,
    output logic [lkvc_pkg::KEY_W-1:0]         ent_key,
    output logic [VALUE_BITS-1:0]              ent_value,
    input  wire lkvc_pkg::tok_t                tok_in,
    input  wire logic [$clog2(ENTRIES)-1:0]    pos_in,
    input  wire logic [VALUE_BITS-1:0]         val_in,
    input  wire logic [lkvc_pkg::KEY_W-1:0]    lru_in,
    output lkvc_pkg::tok_t                     tok_out,
    output logic [$clog2(ENTRIES)-1:0]         pos_out,
    output logic [VALUE_BITS-1:0]              val_out,
    output logic [lkvc_pkg::KEY_W-1:0]         lru_out
);

    import lkvc_pkg::*;

    localparam int POS_W = $clog2(ENTRIES);
    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic                  valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    tok_t                  tok_reg, tok_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [KEY_W-1:0]      lru_reg, lru_next;

    // entry movement
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        unique case (shift_mode)
            SHIFT_HOLD:
            begin
            end
            SHIFT_FRONT:
            begin
                if (MY_POS <= shift_pos)
                begin
                    valid_next = prev_valid;
                    key_next   = prev_key;
                    value_next = prev_value;
                end
            end
            SHIFT_REMOVE:
            begin
                if (MY_POS >= shift_pos)
                begin
                    valid_next = next_valid;
                    key_next   = next_key;
                    value_next = next_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    // token: last valid cell passed is the least recent one
    always_comb
    begin
        tok_next = tok_in;
        pos_next = pos_in;
        val_next = val_in;
        lru_next = lru_in;
        if (tok_in.active && valid_reg)
        begin
            lru_next = key_reg;
            if (key_reg == lookup_key)
            begin
                tok_next.found = 1'b1;
                pos_next       = MY_POS;
                val_next       = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        lru_reg   <= lru_next;
    end

    assign ent_valid = valid_reg;
    assign ent_key   = key_reg;
    assign ent_value = value_reg;
    assign tok_out   = tok_reg;
    assign pos_out   = pos_reg;
    assign val_out   = val_reg;
    assign lru_out   = lru_reg;

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache_unit.sv
// top level of the fully associative lru key-value cache
`default_nettype none

// fully associative key-value cache with least-recently-used replacement.
// entries sit in a row of cells kept in recency order: cell 0 holds the
// most recent entry and the valid entries are always packed at the front,
// so the least recent one is the last valid cell. an operation word
// (tuser = func; tdata = lookup_key, write_value) is taken only while the
// block is idle. a search token then walks the row one cell per clock,
// comparing the key and picking up the hit value and the key of the last
// valid cell; the update then moves the cells up to the target place, or
// from it onward, by one place at once (move to front, insert at front,
// or close the gap after a delete); a get that misses moves nothing. the
// result word is written by the update, and a new operation is taken
// only after the update of the last one; the update waits while an
// earlier result word is still held in the output register. the next
// operation is taken in the clock after the update even if the previous
// result still waits in the output register. the result word carries hit
// and evicted in tuser and read_value, evicted_key in tdata.
// capacity_in_use is written through cfg_wr_en / cfg_wr_data; 0 acts as 1
// and values above ENTRIES act as ENTRIES. no clearing pass is needed
// after reset.

module lru_key_value_cache_unit #(
    parameter int ENTRIES    = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int VALUE_BITS = lkvc_pkg::DEFAULT_VALUE_BITS,
    localparam int DATA_W    = ((lkvc_pkg::KEY_W + VALUE_BITS + 7) / 8) * 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lkvc_pkg::CFG_W-1:0]  cfg_wr_data,   // capacity_in_use
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [DATA_W-1:0]           s_tdata,       // lookup_key, write_value
    input  wire logic [lkvc_pkg::FUNC_W-1:0] s_tuser,       // func
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [DATA_W-1:0]                m_tdata,       // read_value, evicted_key
    output logic [lkvc_pkg::FLAG_W-1:0]      m_tuser        // hit, evicted
);

    import lkvc_pkg::*;

    localparam int POS_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // control
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     capacity_reg;
    logic                 start_reg;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic                 in_fire;
    logic                 upd_fire;
    logic                 out_free;

    // operation being worked on
    func_t                 op_func_reg;
    logic [KEY_W-1:0]      op_key_reg;
    logic [VALUE_BITS-1:0] op_value_reg;

    // search outcome
    logic                  found_reg;
    logic [POS_W-1:0]      fpos_reg;
    logic [VALUE_BITS-1:0] fval_reg;
    logic [KEY_W-1:0]      lru_reg;

    // result word register
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [VALUE_BITS-1:0] m_rval_reg;
    logic                  m_ev_reg;
    logic [KEY_W-1:0]      m_evkey_reg;

    // update decision
    shift_t                shift_mode;
    shift_t                cell_mode;
    logic [POS_W-1:0]      shift_pos;
    logic [VALUE_BITS-1:0] head_value;
    logic                  res_hit;
    logic [VALUE_BITS-1:0] res_rval;
    logic                  res_ev;
    logic [KEY_W-1:0]      res_evkey;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cap_eff;
    logic                  need_evict;

    // entry links: index 0 is the head feed, 1..ENTRIES the cells, last the tail
    logic                  link_valid [ENTRIES+2];
    logic [KEY_W-1:0]      link_key   [ENTRIES+2];
    logic [VALUE_BITS-1:0] link_value [ENTRIES+2];
    logic [ENTRIES-1:0]    valid_vec;

    // token path
    tok_t                  tok_chain [ENTRIES+1];
    logic [POS_W-1:0]      pos_chain [ENTRIES+1];
    logic [VALUE_BITS-1:0] val_chain [ENTRIES+1];
    logic [KEY_W-1:0]      lru_chain [ENTRIES+1];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // effective capacity clamped to 1 .. ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        cap_eff = cap_ext;
        priority if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign need_evict = (CMP_W'(occ_reg) >= cap_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok_chain[ENTRIES].active)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        upd_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SEARCH:
            begin
            end
            ST_UPDATE:
            begin
                upd_fire = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // what the update clock does with the row, and the result word
    always_comb
    begin
        shift_mode = SHIFT_HOLD;
        shift_pos  = fpos_reg;
        head_value = op_value_reg;
        occ_next   = occ_reg;
        res_hit    = 1'b0;
        res_rval   = '0;
        res_ev     = 1'b0;
        res_evkey  = '0;
        unique case (op_func_reg)
            FUNC_GET:
            begin
                if (found_reg)
                begin
                    shift_mode = SHIFT_FRONT;
                    head_value = fval_reg;
                    res_hit    = 1'b1;
                    res_rval   = fval_reg;
                end
            end
            FUNC_PUT:
            begin
                shift_mode = SHIFT_FRONT;
                priority if (found_reg)
                begin
                    res_hit = 1'b1;
                end
                else if (need_evict)
                begin
                    // the last valid cell is overwritten by the shift
                    shift_pos = POS_W'(occ_reg - CNT_W'(1));
                    res_ev    = 1'b1;
                    res_evkey = lru_reg;
                end
                else
                begin
                    shift_pos = POS_W'(occ_reg);
                    occ_next  = occ_reg + CNT_W'(1);
                end
            end
            FUNC_DELETE:
            begin
                if (found_reg)
                begin
                    shift_mode = SHIFT_REMOVE;
                    res_hit    = 1'b1;
                    occ_next   = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cell_mode = upd_fire ? shift_mode : SHIFT_HOLD;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_fire;
            if (upd_fire)
            begin
                occ_reg <= occ_next;
            end
            priority if (upd_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // operation, search outcome and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_func_reg  <= func_t'(s_tuser);
            op_key_reg   <= s_tdata[KEY_W-1:0];
            op_value_reg <= s_tdata[KEY_W +: VALUE_BITS];
        end
        if (tok_chain[ENTRIES].active)
        begin
            found_reg <= tok_chain[ENTRIES].found;
            fpos_reg  <= pos_chain[ENTRIES];
            fval_reg  <= val_chain[ENTRIES];
            lru_reg   <= lru_chain[ENTRIES];
        end
        if (upd_fire)
        begin
            m_hit_reg   <= res_hit;
            m_rval_reg  <= res_rval;
            m_ev_reg    <= res_ev;
            m_evkey_reg <= res_evkey;
        end
    end

    // head feed is the entry that goes to the front, tail feeds an empty cell
    assign link_valid[0]         = 1'b1;
    assign link_key[0]           = op_key_reg;
    assign link_value[0]         = head_value;
    assign link_valid[ENTRIES+1] = 1'b0;
    assign link_key[ENTRIES+1]   = '0;
    assign link_value[ENTRIES+1] = '0;

    // token enters cell 0 the clock after acceptance
    assign tok_chain[0] = '{active: start_reg, found: 1'b0};
    assign pos_chain[0] = '0;
    assign val_chain[0] = '0;
    assign lru_chain[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkvc_cell #(
            .ENTRIES    (ENTRIES),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_mode (cell_mode),
            .shift_pos  (shift_pos),
            .lookup_key (op_key_reg),
            .prev_valid (link_valid[g]),
            .prev_key   (link_key[g]),
            .prev_value (link_value[g]),
            .next_valid (link_valid[g+2]),
            .next_key   (link_key[g+2]),
            .next_value (link_value[g+2]),
            .ent_valid  (link_valid[g+1]),
            .ent_key    (link_key[g+1]),
            .ent_value  (link_value[g+1]),
            .tok_in     (tok_chain[g]),
            .pos_in     (pos_chain[g]),
            .val_in     (val_chain[g]),
            .lru_in     (lru_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .pos_out    (pos_chain[g+1]),
            .val_out    (val_chain[g+1]),
            .lru_out    (lru_chain[g+1])
        );

        assign valid_vec[g] = link_valid[g+1];
    end

    // result word
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({m_evkey_reg, m_rval_reg});
    assign m_tuser  = {m_ev_reg, m_hit_reg};

`ifndef SYNTHESIS
    // fill count never exceeds the row
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
    else $error("occupancy beyond entry count");

    // fill count agrees with the valid cells whenever the row is at rest
    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == int'(occ_reg)))
    else $error("occupancy does not match valid cells");

    // the token leaves the row only during a search
    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_chain[ENTRIES].active |-> (state_reg == ST_SEARCH))
    else $error("search token outside search state");

    // no result reports both a hit and an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_hit_reg && m_ev_reg))
    else $error("hit and eviction in one result");
`endif

endmodule

`default_nettype wire
